[rtl/gated_moving_average_filter_assert.svh]
// Assertion macros for the gated moving-average filter.
// Expects clk and rst in the scope of each use.
`ifndef GATED_MOVING_AVERAGE_FILTER_ASSERT_SVH
`define GATED_MOVING_AVERAGE_FILTER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GMAF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gated_moving_average_filter: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define GMAF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gated_moving_average_filter: next-cycle check failed");

`endif

[rtl/gmaf_pkg.sv]
// Shared constants and register codes for the gated moving-average filter.
// No dependencies.
package gmaf_pkg;

  localparam int SAMPLE_W = 8;
  localparam int WINDOW = 5;
  localparam int IDX_W = $clog2(WINDOW);
  localparam int SUM_W = $clog2(WINDOW * ((1 << SAMPLE_W) - 1) + 1);

  // Exact divide by WINDOW: multiply by a rounded-up reciprocal, then shift.
  localparam int DIV_SHIFT = SUM_W + $clog2(WINDOW);
  localparam int RECIP_W = SUM_W + 2;
  localparam int RECIP = ((1 << DIV_SHIFT) + WINDOW - 1) / WINDOW;
  localparam int PROD_W = SUM_W + RECIP_W;

  localparam logic [SAMPLE_W-1:0] RESET_LEVEL = SAMPLE_W'(76);
  localparam logic [SAMPLE_W-1:0] JUMP_LIMIT_RESET = SAMPLE_W'(10);
  localparam logic [SAMPLE_W-1:0] DEADBAND_RESET = SAMPLE_W'(1);
  localparam logic [SUM_W-1:0] SUM_RESET = SUM_W'(WINDOW * 76);

  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;
  localparam int REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_JUMP_LIMIT = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_DEADBAND = 1'b1;

  typedef logic [SAMPLE_W-1:0] sample_t;

endpackage

[rtl/gmaf_if.sv]
// Stream interfaces of the gated moving-average filter: samples in, results out.
// Depends on gmaf_pkg.
interface gmaf_sample_if;
  import gmaf_pkg::*;

  logic valid;
  logic ready;
  sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface gmaf_result_if;
  import gmaf_pkg::*;

  logic valid;
  logic ready;
  sample_t filtered_weight;
  logic accepted;

  modport source (output valid, output filtered_weight, output accepted, input ready);
  modport sink (input valid, input filtered_weight, input accepted, output ready);
endinterface

[rtl/gated_moving_average_filter.sv]
// Gated moving-average filter: takes one sample per cycle unless results stall and returns
// one result for each from a single result register, in the next cycle. A sample is kept
// only if its distance from the last kept sample lies strictly between the deadband and
// the jump limit; the filtered weight then becomes the mean of the window as it stood
// before the sample was stored. The running sum and a reciprocal multiply give the mean
// in the same cycle, so throughput is one item per clock while the result side takes
// one transfer per clock. jump_limit sits at byte address 0, deadband at 4.
// Depends on gmaf_pkg, gmaf_if.sv and gated_moving_average_filter_assert.svh.
module gated_moving_average_filter (
  input  logic                          clk,
  input  logic                          rst,
  gmaf_sample_if.sink                   samples,
  gmaf_result_if.source                 results,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gmaf_pkg::ADDR_W-1:0]   paddr,
  input  logic [gmaf_pkg::DATA_W-1:0]   pwdata,
  output logic [gmaf_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import gmaf_pkg::*;

  sample_t jump_limit;
  sample_t deadband;
  sample_t win [WINDOW];
  logic [IDX_W-1:0] wr_idx;
  logic [IDX_W-1:0] wr_idx_next;
  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] sum_next;
  sample_t last_accepted;
  sample_t held;

  logic res_valid;
  sample_t res_weight;
  logic res_accepted;

  logic in_fire;
  logic cfg_write;
  logic [REG_IDX_W-1:0] reg_idx;
  sample_t diff;
  logic pass;
  logic [PROD_W-1:0] prod;
  sample_t mean;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_idx = paddr[ADDR_W-1:ADDR_W-REG_IDX_W];

  always_comb begin
    unique case (reg_idx)
      REG_JUMP_LIMIT: prdata = DATA_W'(jump_limit);
      REG_DEADBAND:   prdata = DATA_W'(deadband);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      jump_limit <= JUMP_LIMIT_RESET;
      deadband <= DEADBAND_RESET;
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_JUMP_LIMIT: jump_limit <= pwdata[SAMPLE_W-1:0];
        REG_DEADBAND:   deadband <= pwdata[SAMPLE_W-1:0];
        default:        ;
      endcase
    end
  end

  // Gate and mean
  assign samples.ready = !res_valid || results.ready;
  assign in_fire = samples.valid && samples.ready;

  always_comb begin
    if (samples.sample >= last_accepted) begin
      diff = samples.sample - last_accepted;
    end else begin
      diff = last_accepted - samples.sample;
    end
  end

  assign pass = (diff < jump_limit) && (diff > deadband);
  assign prod = PROD_W'(sum) * PROD_W'(RECIP_W'(RECIP));
  assign mean = prod[DIV_SHIFT +: SAMPLE_W];

  assign sum_next = sum - SUM_W'(win[wr_idx]) + SUM_W'(samples.sample);
  assign wr_idx_next = (wr_idx == IDX_W'(WINDOW - 1)) ? '0 : wr_idx + 1'b1;

  // Window state: advance only on a kept sample
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < WINDOW; k++) begin
        win[k] <= RESET_LEVEL;
      end
      wr_idx <= '0;
      sum <= SUM_RESET;
      last_accepted <= RESET_LEVEL;
      held <= RESET_LEVEL;
    end else if (in_fire && pass) begin
      win[wr_idx] <= samples.sample;
      wr_idx <= wr_idx_next;
      sum <= sum_next;
      last_accepted <= samples.sample;
      held <= mean;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (in_fire) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_weight <= pass ? mean : held;
      res_accepted <= pass;
    end
  end

  assign results.valid = res_valid;
  assign results.filtered_weight = res_weight;
  assign results.accepted = res_accepted;

`include "gated_moving_average_filter_assert.svh"

  `GMAF_ASSERT_NOW(a_idx_range, 1'b1, wr_idx <= IDX_W'(WINDOW - 1))
  `GMAF_ASSERT_NEXT(a_reject_holds, in_fire && !pass, $stable(last_accepted) && $stable(sum) && $stable(held))
  `GMAF_ASSERT_NEXT(a_result_follows, in_fire, res_valid && res_accepted == $past(pass) && res_weight == held)

endmodule

[sim/gmaf_weight_scoreboard.sv]
`timescale 1ns / 1ps
// Scoreboard for the gated moving-average filter: follows the register port, predicts
// one result per sample transfer and checks the result stream against it in order.
// Depends on gmaf_pkg and the stream interfaces in gmaf_if.sv.
module gmaf_weight_scoreboard (
  input  logic                        clk,
  input  logic                        rst,
  gmaf_sample_if                      samples,
  gmaf_result_if                      results,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [gmaf_pkg::ADDR_W-1:0] paddr,
  input  logic [gmaf_pkg::DATA_W-1:0] pwdata,
  output int                          mismatches,
  output int                          outstanding
);
  import gmaf_pkg::*;

  typedef struct packed {
    sample_t filtered_weight;
    logic    accepted;
  } weight_result_t;

  sample_t          window_samples [WINDOW];
  logic [IDX_W-1:0] slot;
  sample_t          last_kept;
  sample_t          held_weight;
  sample_t          jump_limit;
  sample_t          deadband;
  weight_result_t   expected_weights [$];

  initial begin
    mismatches = 0;
    outstanding = 0;
  end

  function automatic weight_result_t gate_and_average(sample_t s);
    weight_result_t r;
    int sum;
    sample_t gap;
    gap = (s >= last_kept) ? s - last_kept : last_kept - s;
    r.accepted = (gap < jump_limit) && (gap > deadband);
    if (r.accepted) begin
      // mean of the window as it stood before this sample goes in
      sum = 0;
      for (int k = 0; k < WINDOW; k++) sum += window_samples[k];
      held_weight = sample_t'(sum / WINDOW);
      window_samples[slot] = s;
      last_kept = s;
      slot = (slot == IDX_W'(WINDOW - 1)) ? '0 : slot + 1'b1;
    end
    r.filtered_weight = held_weight;
    return r;
  endfunction

  always @(posedge clk) begin
    weight_result_t got;
    weight_result_t want;
    if (rst) begin
      for (int k = 0; k < WINDOW; k++) window_samples[k] = RESET_LEVEL;
      slot = '0;
      last_kept = RESET_LEVEL;
      held_weight = RESET_LEVEL;
      jump_limit = JUMP_LIMIT_RESET;
      deadband = DEADBAND_RESET;
      expected_weights.delete();
      mismatches <= 0;
      outstanding <= 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00) begin
        case (paddr[ADDR_W-1:2])
          REG_JUMP_LIMIT: jump_limit = pwdata[SAMPLE_W-1:0];
          REG_DEADBAND:   deadband = pwdata[SAMPLE_W-1:0];
          default: ;
        endcase
      end
      // pop before push: a result never belongs to a sample taken at the same edge
      if (results.valid && results.ready) begin
        got.filtered_weight = results.filtered_weight;
        got.accepted = results.accepted;
        if (expected_weights.size() == 0) begin
          $display("%0t: result with nothing outstanding: filtered_weight %0d accepted %0b",
                   $time, got.filtered_weight, got.accepted);
          mismatches <= mismatches + 1;
        end else begin
          want = expected_weights.pop_front();
          if (got.filtered_weight !== want.filtered_weight ||
              got.accepted !== want.accepted) begin
            $display("%0t: filtered_weight expected %0d actual %0d, accepted expected %0b actual %0b",
                     $time, want.filtered_weight, got.filtered_weight,
                     want.accepted, got.accepted);
            mismatches <= mismatches + 1;
          end
        end
      end
      if (samples.valid && samples.ready)
        expected_weights.push_back(gate_and_average(samples.sample));
      outstanding <= expected_weights.size();
    end
  end

endmodule

[sim/gated_moving_average_filter_test.sv]
`timescale 1ns / 1ps
// Top of the gated moving-average filter test: clock, reset, register writes, sample
// bursts and result back-pressure; the scoreboard beside the filter does the checking.
// Depends on gmaf_pkg, gmaf_if.sv, gmaf_weight_scoreboard.sv and the filter RTL.
module gated_moving_average_filter_test;
  import gmaf_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 80;
  localparam int PHASES = 10;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  int                mismatches;
  int                outstanding;
  int                cycles;
  logic              long_hold;
  sample_t           walk_level;

  gmaf_sample_if sample_ch ();
  gmaf_result_if result_ch ();

  gated_moving_average_filter uut (
    .clk     (clk),
    .rst     (rst),
    .samples (sample_ch),
    .results (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  gmaf_weight_scoreboard weight_check (
    .clk         (clk),
    .rst         (rst),
    .samples     (sample_ch),
    .results     (result_ch),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    sample_ch.valid = 1'b0;
    sample_ch.sample = '0;
    result_ch.ready = 1'b0;
    long_hold = 1'b0;
    walk_level = RESET_LEVEL;
  end

  // Upper data bits are random: only the low byte of each register is kept.
  task automatic write_reg(logic [REG_IDX_W-1:0] idx, sample_t value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(idx) << 2;
    pwdata <= {(DATA_W - SAMPLE_W)'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic push_sample(sample_t s);
    sample_ch.valid <= 1'b1;
    sample_ch.sample <= s;
    do @(posedge clk); while (!sample_ch.ready);
  endtask

  task automatic pause_sender(int n);
    sample_ch.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Hold off until every expected result has been taken.
  task automatic wait_drained();
    sample_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Mostly a random walk that stays within reach of its own previous step, some noise.
  function automatic sample_t pick_sample(int reach);
    int offset;
    int v;
    if ($urandom_range(0, 4) == 0) return sample_t'($urandom);
    offset = $urandom_range(0, 2 * reach);
    v = int'(walk_level) + offset - reach;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    walk_level = sample_t'(v);
    return walk_level;
  endfunction

  task automatic run_phase(sample_t jl, sample_t db, int items, bit squeeze);
    int sent;
    int burst;
    int reach;
    wait_drained();
    write_reg(REG_JUMP_LIMIT, jl);
    write_reg(REG_DEADBAND, db);
    reach = (jl < 2) ? 2 : int'(jl);
    sent = 0;
    while (sent < items) begin
      burst = $urandom_range(1, 24);
      if (squeeze && sent == 0) begin
        long_hold = 1'b1;
        burst = 40;
      end
      for (int k = 0; k < burst && sent < items; k++) begin
        push_sample(pick_sample(reach));
        sent++;
      end
      if (squeeze && sent == burst) wait_drained();
      else if ($urandom_range(0, 1) == 1) pause_sender($urandom_range(1, 9));
    end
  endtask

  // Receiver: back-pressure in modes of random length, plus one long hold on request.
  initial begin
    int mode;
    int left;
    mode = 0;
    left = 0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
        result_ch.ready <= 1'b1;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 2);
          left = $urandom_range(10, 60);
        end
        left--;
        case (mode)
          0: result_ch.ready <= 1'b1;
          1: result_ch.ready <= 1'($urandom_range(0, 1));
          default: result_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("gated_moving_average_filter_test: errors");
    $finish;
  end

  initial begin
    sample_t at_reset [9];
    sample_t wide_gate [7];
    sample_t jl_set [PHASES];
    sample_t db_set [PHASES];
    int      item_set [PHASES];
    at_reset = '{8'd76, 8'd77, 8'd78, 8'd87, 8'd97, 8'd0, 8'd255, 8'd86, 8'd85};
    wide_gate = '{8'd0, 8'd255, 8'd254, 8'd0, 8'd255, 8'd1, 8'd255};
    jl_set = '{8'd255, 8'd2, 8'd128, 8'd60, 8'd20, 8'd200, 8'd255, 8'd0, 8'd0, 8'd0};
    db_set = '{8'd0, 8'd0, 8'd3, 8'd5, 8'd1, 8'd150, 8'd254, 8'd255, 8'd0, 8'd0};
    item_set = '{220, 150, 220, 220, 220, 150, 60, 40, 220, 220};
    jl_set[8] = sample_t'($urandom_range(2, 255));
    db_set[8] = sample_t'($urandom_range(0, jl_set[8] - 2));
    jl_set[9] = sample_t'($urandom_range(2, 255));
    db_set[9] = sample_t'($urandom_range(0, jl_set[9] - 2));

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset gate: equal sample, difference at the deadband, at the jump limit, extremes
    foreach (at_reset[k]) push_sample(at_reset[k]);
    wait_drained();
    // widest gate: full-scale swings, a difference of 255 still rejected
    write_reg(REG_JUMP_LIMIT, 8'd255);
    write_reg(REG_DEADBAND, 8'd0);
    foreach (wide_gate[k]) push_sample(wide_gate[k]);
    wait_drained();
    // empty gates: nothing can pass, output holds
    write_reg(REG_JUMP_LIMIT, 8'd0);
    push_sample(8'd128);
    push_sample(8'd254);
    wait_drained();
    write_reg(REG_JUMP_LIMIT, 8'd5);
    write_reg(REG_DEADBAND, 8'd4);
    push_sample(8'd250);
    push_sample(8'd251);
    push_sample(8'd0);
    wait_drained();
    // only a difference of one passes
    write_reg(REG_JUMP_LIMIT, 8'd2);
    write_reg(REG_DEADBAND, 8'd0);
    push_sample(8'd254);
    push_sample(8'd253);
    push_sample(8'd253);
    push_sample(8'd251);

    for (int p = 0; p < PHASES; p++) run_phase(jl_set[p], db_set[p], item_set[p], p == 2);

    wait_drained();
    repeat (4) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("gated_moving_average_filter_test: clean");
    end else begin
      $display("gated_moving_average_filter_test: errors");
    end
    $finish;
  end

endmodule

[gated_moving_average_filter.f]
+incdir+rtl
rtl/gmaf_pkg.sv
rtl/gmaf_if.sv
rtl/gated_moving_average_filter.sv
sim/gmaf_weight_scoreboard.sv
sim/gated_moving_average_filter_test.sv
